### rtl/rhsv_pkg.sv
// shared types and constants for the rgb to hsv converter
package rhsv_pkg;

  // field widths of one item in each direction
  localparam int IN_BITS     = 8;
  localparam int HUE_BITS    = 15;
  localparam int SAT_BITS    = 13;
  localparam int BRIGHT_BITS = 8;

  // quotient bits resolved by the cell row, one bit per cell
  localparam int QUO_BITS = 13;

  // fixed point scale factors
  localparam int SAT_SHIFT   = 12;
  localparam int HUE_SECTOR  = 3840;
  localparam int HUE_CIRCLE  = 23040;
  localparam int HUE_GREEN   = 7680;
  localparam int HUE_BLUE    = 15360;

  // sector codes, chosen by the largest component
  localparam logic [1:0] SECT_RED   = 2'd0;
  localparam logic [1:0] SECT_GREEN = 2'd1;
  localparam logic [1:0] SECT_BLUE  = 2'd2;

  typedef struct packed {
    logic [IN_BITS-1:0] red;
    logic [IN_BITS-1:0] green;
    logic [IN_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_BITS-1:0]    hue;
    logic [SAT_BITS-1:0]    saturation;
    logic [BRIGHT_BITS-1:0] brightness;
  } hsv_t;

  // item tag that rides along the cell row
  typedef struct packed {
    logic                   valid;
    logic                   black;
    logic                   grey;
    logic                   neg;
    logic [1:0]             sector;
    logic [BRIGHT_BITS-1:0] bright;
  } tag_t;

  // fixed width part of both dividers: pending dividend bits and quotients
  typedef struct packed {
    logic [QUO_BITS-1:0] low_s;
    logic [QUO_BITS-1:0] low_h;
    logic [QUO_BITS-1:0] q_s;
    logic [QUO_BITS-1:0] q_h;
  } lane_t;

endpackage

### rtl/rhsv_front.sv
// input stage: max, min, sector pick and divider setup
module rhsv_front import rhsv_pkg::*; #(
  parameter int CW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  pixel_t        pixel,
  output logic [CW-1:0] rem_s,
  output logic [CW-1:0] rem_h,
  output logic [CW-1:0] div_s,
  output logic [CW-1:0] div_h,
  output lane_t         lane,
  output tag_t          tag
);

  localparam int IW = (CW < IN_BITS) ? CW : IN_BITS;
  localparam int NW = CW + SAT_SHIFT;

  logic [CW-1:0]   r_c, g_c, b_c;
  logic [CW-1:0]   mx, mn, d, op_a, op_b, e;
  logic [1:0]      sector;
  logic            neg;
  logic [NW-1:0]   n_s, n_h;

  // components masked to the configured width
  assign r_c = CW'(pixel.red[IW-1:0]);
  assign g_c = CW'(pixel.green[IW-1:0]);
  assign b_c = CW'(pixel.blue[IW-1:0]);

  // extremes and sector, ties go to red and then green
  always_comb begin
    mx = r_c;
    mn = r_c;
    if (g_c > mx) mx = g_c;
    if (b_c > mx) mx = b_c;
    if (g_c < mn) mn = g_c;
    if (b_c < mn) mn = b_c;
    d = mx - mn;
    if (mx == r_c) begin
      sector = SECT_RED;
      op_a   = g_c;
      op_b   = b_c;
    end else if (mx == g_c) begin
      sector = SECT_GREEN;
      op_a   = b_c;
      op_b   = r_c;
    end else begin
      sector = SECT_BLUE;
      op_a   = r_c;
      op_b   = g_c;
    end
    neg = (op_a < op_b);
    e   = neg ? (op_b - op_a) : (op_a - op_b);
  end

  // dividends: d * 4096 and e * 3840 as shift and subtract
  assign n_s = NW'(d) << SAT_SHIFT;
  assign n_h = (NW'(e) << SAT_SHIFT) - (NW'(e) << 8);

  // valid bit is reset; payload, where upper dividend bits seed the remainder, is not
  always_ff @(posedge clk) begin
    if (rst) begin
      tag.valid <= 1'b0;
    end else begin
      tag.valid <= load;
    end
    rem_s      <= CW'(n_s >> QUO_BITS);
    rem_h      <= CW'(n_h >> QUO_BITS);
    div_s      <= mx;
    div_h      <= d;
    lane.low_s <= n_s[QUO_BITS-1:0];
    lane.low_h <= n_h[QUO_BITS-1:0];
    lane.q_s   <= '0;
    lane.q_h   <= '0;
    tag.black  <= (mx == '0);
    tag.grey   <= (d == '0);
    tag.neg    <= neg;
    tag.sector <= sector;
    tag.bright <= BRIGHT_BITS'(mx);
  end

endmodule

### rtl/rhsv_cell.sv
// one cell of the divider row: one quotient bit of each division
module rhsv_cell import rhsv_pkg::*; #(
  parameter int CW   = 8,
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [CW-1:0] rem_s_in,
  input  logic [CW-1:0] rem_h_in,
  input  logic [CW-1:0] div_s_in,
  input  logic [CW-1:0] div_h_in,
  input  lane_t         lane_in,
  input  tag_t          tag_in,
  output logic [CW-1:0] rem_s,
  output logic [CW-1:0] rem_h,
  output logic [CW-1:0] div_s,
  output logic [CW-1:0] div_h,
  output lane_t         lane,
  output tag_t          tag
);

  localparam int BIT = QUO_BITS - 1 - STEP;

  logic [CW:0] t_s, t_h;
  logic        ge_s, ge_h;

  // bring down the next dividend bit and try the subtract
  assign t_s  = {rem_s_in, lane_in.low_s[BIT]};
  assign t_h  = {rem_h_in, lane_in.low_h[BIT]};
  assign ge_s = (t_s >= {1'b0, div_s_in});
  assign ge_h = (t_h >= {1'b0, div_h_in});

  // valid bit is reset; remainders, quotients and carried payload are not
  always_ff @(posedge clk) begin
    if (rst) begin
      tag.valid <= 1'b0;
    end else begin
      tag.valid <= tag_in.valid;
    end
    rem_s      <= ge_s ? CW'(t_s - {1'b0, div_s_in}) : t_s[CW-1:0];
    rem_h      <= ge_h ? CW'(t_h - {1'b0, div_h_in}) : t_h[CW-1:0];
    div_s      <= div_s_in;
    div_h      <= div_h_in;
    lane.low_s <= lane_in.low_s;
    lane.low_h <= lane_in.low_h;
    lane.q_s   <= {lane_in.q_s[QUO_BITS-2:0], ge_s};
    lane.q_h   <= {lane_in.q_h[QUO_BITS-2:0], ge_h};
    tag.black  <= tag_in.black;
    tag.grey   <= tag_in.grey;
    tag.neg    <= tag_in.neg;
    tag.sector <= tag_in.sector;
    tag.bright <= tag_in.bright;
  end

endmodule

### rtl/rhsv_back.sv
// output stage: hue offset, wrap, special cases and result register
module rhsv_back import rhsv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  lane_t lane,
  input  tag_t  tag,
  output logic  strobe,
  output hsv_t  result
);

  logic [15:0] base, mag, sum, hue_w;

  // sector offset
  always_comb begin
    case (tag.sector)
      SECT_RED:   base = 16'd0;
      SECT_GREEN: base = 16'(HUE_GREEN);
      SECT_BLUE:  base = 16'(HUE_BLUE);
      default:    base = 16'd0;
    endcase
  end

  // signed add in two's complement, wrap a negative hue by a full circle
  always_comb begin
    mag   = 16'(lane.q_h);
    sum   = base + (tag.neg ? (~mag + 16'd1) : mag);
    hue_w = sum[15] ? (sum + 16'(HUE_CIRCLE)) : sum;
  end

  // strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= tag.valid;
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    result.hue        <= tag.grey ? '0 : hue_w[HUE_BITS-1:0];
    result.saturation <= tag.black ? '0 : lane.q_s;
    result.brightness <= tag.bright;
  end

endmodule

### rtl/rgb_to_hsv_converter.sv
// top level of the rgb to hsv converter
//
// Usage:
//   Drive pixel and raise start; the item is taken at a clock edge where
//   start is high and busy is low. busy is high only while rst is high,
//   so outside reset one item can be taken on every clock.
//   Each result appears on result for exactly one cycle with strobe high.
//   The receiver cannot hold results off and must take it in that cycle.
// Throughput and pipeline:
//   One item per clock outside reset. Each item passes through one setup
//   stage, a row of 13 divider cells that each resolve one quotient bit
//   of the saturation and of the hue division, and one output stage.
// Reset:
//   rst is synchronous; it clears the valid bits along the pipeline so no
//   strobe follows, and items in flight are dropped. Payload registers are
//   not reset.
module rgb_to_hsv_converter import rhsv_pkg::*; #(
  parameter int COMPONENT_BITS = 8
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  output logic   busy,
  input  pixel_t pixel,
  output logic   strobe,
  output hsv_t   result
);

  localparam int CW = COMPONENT_BITS;

  logic [CW-1:0] rem_s [0:QUO_BITS];
  logic [CW-1:0] rem_h [0:QUO_BITS];
  logic [CW-1:0] div_s [0:QUO_BITS];
  logic [CW-1:0] div_h [0:QUO_BITS];
  lane_t         lane  [0:QUO_BITS];
  tag_t          tag   [0:QUO_BITS];

  // items are refused only during reset
  assign busy = rst;

  // setup stage
  rhsv_front #(.CW(CW)) u_front (
    .clk   (clk),
    .rst   (rst),
    .load  (start && !busy),
    .pixel (pixel),
    .rem_s (rem_s[0]),
    .rem_h (rem_h[0]),
    .div_s (div_s[0]),
    .div_h (div_h[0]),
    .lane  (lane[0]),
    .tag   (tag[0])
  );

  // divider row, most significant quotient bit first
  for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
    rhsv_cell #(.CW(CW), .STEP(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .rem_s_in (rem_s[i]),
      .rem_h_in (rem_h[i]),
      .div_s_in (div_s[i]),
      .div_h_in (div_h[i]),
      .lane_in  (lane[i]),
      .tag_in   (tag[i]),
      .rem_s    (rem_s[i+1]),
      .rem_h    (rem_h[i+1]),
      .div_s    (div_s[i+1]),
      .div_h    (div_h[i+1]),
      .lane     (lane[i+1]),
      .tag      (tag[i+1])
    );
  end

  // output stage
  rhsv_back u_back (
    .clk    (clk),
    .rst    (rst),
    .lane   (lane[QUO_BITS]),
    .tag    (tag[QUO_BITS]),
    .strobe (strobe),
    .result (result)
  );

endmodule

### rtl/rhsv_checker.sv
// port level checks for the rgb to hsv converter and their binding
module rhsv_checker import rhsv_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   start,
  input logic   busy,
  input logic   strobe,
  input hsv_t   result
);

  // no result right after a reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !strobe)
    else $error("strobe after reset");

  // every item taken yields its result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##15 strobe)
    else $error("result missing for taken item");

  // no result without a matching item taken before
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start && !busy, 15))
    else $error("result without item");

  // result fields stay in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (result.hue < 15'(HUE_CIRCLE)) && (result.saturation <= 13'd4096))
    else $error("hue or saturation out of range");

  // black pixel has no hue and no saturation
  a_black: assert property (@(posedge clk) disable iff (rst)
    (strobe && (result.brightness == '0)) |->
      ((result.hue == '0) && (result.saturation == '0)))
    else $error("black pixel with hue or saturation");

endmodule

bind rgb_to_hsv_converter rhsv_checker u_rhsv_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);

### sim/testbench.sv
// testbench for the rgb to hsv converter: directed and random pixels checked against a local model
`timescale 1ns / 1ps

module testbench;
  import rhsv_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 24;
  localparam int RANDOM_PIXELS = 500;

  // one pixel waiting to go out, with its lead-in gap and a drain request
  typedef struct {
    pixel_t px;
    int     gap;
    bit     drain;
  } pending_pixel_t;

  // predicted conversion of one accepted pixel
  typedef struct {
    pixel_t px;
    hsv_t   hsv;
  } hsv_entry_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   start = 1'b0;
  logic   busy;
  pixel_t pixel = '0;
  logic   strobe;
  hsv_t   result;

  pending_pixel_t pixel_queue[$];
  hsv_entry_t     hsv_pending[$];

  int gap_count = 0;
  int stall_cycles = 0;
  int pixels_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int grey_pixels = 0;
  int burst_left = 0;

  rgb_to_hsv_converter dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .pixel  (pixel),
    .strobe (strobe),
    .result (result)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // fixed point hsv of one pixel, hue sector ties go to red then green
  function automatic hsv_t convert_pixel(pixel_t px);
    int r, g, b, mx, mn, span, h;
    logic [1:0] sector;
    hsv_t hsv;
    r = px.red;
    g = px.green;
    b = px.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    span = mx - mn;
    h = 0;
    hsv.brightness = BRIGHT_BITS'(mx);
    hsv.saturation = (mx > 0) ? SAT_BITS'((span << SAT_SHIFT) / mx) : '0;
    if (span > 0) begin
      if (mx == r) sector = SECT_RED;
      else if (mx == g) sector = SECT_GREEN;
      else sector = SECT_BLUE;
      case (sector)
        SECT_RED:   h = (HUE_SECTOR * (g - b)) / span;
        SECT_GREEN: h = (HUE_SECTOR * (b - r)) / span + HUE_GREEN;
        default:    h = (HUE_SECTOR * (r - g)) / span + HUE_BLUE;
      endcase
      if (h < 0) h += HUE_CIRCLE;
    end
    hsv.hue = HUE_BITS'(h);
    return hsv;
  endfunction

  task automatic add_pixel(int r, int g, int b, int gap, bit drain);
    pending_pixel_t item;
    item.px.red = 8'(r);
    item.px.green = 8'(g);
    item.px.blue = 8'(b);
    item.gap = gap;
    item.drain = drain;
    pixel_queue.push_back(item);
  endtask

  task automatic note_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%t: %s", $realtime, msg);
  endtask

  // random lead-in gap: mostly none, some short, a few long, plus bursts with none
  function automatic int draw_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if (roll < 5) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // driver: present the next pixel once its gap has passed
  always @(posedge clk) begin : drive_pixels
    pending_pixel_t nxt;
    hsv_entry_t entry;
    if (rst) begin
      start <= 1'b0;
      gap_count <= 0;
    end else begin
      if (start && !busy) begin
        entry.px = pixel;
        entry.hsv = convert_pixel(pixel);
        hsv_pending.push_back(entry);
        pixels_sent++;
        if (pixel.red == pixel.green && pixel.green == pixel.blue) grey_pixels++;
      end
      if (!(start && busy)) begin
        if (pixel_queue.size() == 0) begin
          start <= 1'b0;
        end else if (pixel_queue[0].drain && hsv_pending.size() != 0) begin
          start <= 1'b0;
        end else if (gap_count < pixel_queue[0].gap) begin
          gap_count <= gap_count + 1;
          start <= 1'b0;
        end else begin
          nxt = pixel_queue.pop_front();
          pixel <= nxt.px;
          start <= 1'b1;
          gap_count <= 0;
        end
      end
    end
  end

  // monitor: compare each strobed result with the oldest prediction
  always @(posedge clk) begin : check_results
    hsv_entry_t want;
    if (!rst && strobe) begin
      if (hsv_pending.size() == 0) begin
        note_error($sformatf("unexpected result hue %0d sat %0d val %0d",
                             result.hue, result.saturation, result.brightness));
      end else begin
        want = hsv_pending.pop_front();
        results_checked++;
        if (result.hue !== want.hsv.hue || result.saturation !== want.hsv.saturation ||
            result.brightness !== want.hsv.brightness)
          note_error($sformatf(
            "rgb %0d,%0d,%0d: expected hue %0d sat %0d val %0d, got hue %0d sat %0d val %0d",
            want.px.red, want.px.green, want.px.blue,
            want.hsv.hue, want.hsv.saturation, want.hsv.brightness,
            result.hue, result.saturation, result.brightness));
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin
    int kind, v, lo, hi;
    int r, g, b;

    // black, white, grey
    add_pixel(0, 0, 0, 0, 0);
    add_pixel(255, 255, 255, 0, 0);
    add_pixel(128, 128, 128, 0, 0);
    // primaries and their sectors
    add_pixel(255, 0, 0, 0, 0);
    add_pixel(0, 255, 0, 0, 0);
    add_pixel(0, 0, 255, 0, 0);
    // ties for the largest component
    add_pixel(255, 255, 0, 0, 0);
    add_pixel(0, 255, 255, 0, 0);
    add_pixel(255, 0, 255, 0, 0);
    add_pixel(200, 200, 200, 1, 0);
    // red sector with negative hue wraps around
    add_pixel(255, 0, 1, 0, 0);
    add_pixel(200, 10, 150, 0, 0);
    // both signs in green and blue sectors
    add_pixel(1, 255, 0, 0, 0);
    add_pixel(0, 255, 1, 0, 0);
    add_pixel(1, 0, 255, 0, 0);
    add_pixel(0, 1, 255, 0, 0);
    // smallest spans and smallest maxima, then two wider spans, the last one drained first
    add_pixel(1, 0, 0, 30, 0);
    add_pixel(1, 1, 0, 0, 0);
    add_pixel(0, 0, 1, 0, 0);
    add_pixel(255, 254, 254, 0, 0);
    add_pixel(254, 255, 253, 0, 0);
    add_pixel(170, 85, 255, 0, 0);
    add_pixel(255, 1, 1, 0, 1);

    // random pixels, weighted toward grey, ties and extremes
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      kind = $urandom_range(0, 9);
      r = $urandom_range(0, 255);
      g = $urandom_range(0, 255);
      b = $urandom_range(0, 255);
      case (kind)
        5: begin
          g = r;
          b = r;
        end
        6: begin
          v = $urandom_range(1, 255);
          lo = $urandom_range(0, v);
          case ($urandom_range(0, 2))
            0: begin r = v; g = v; b = lo; end
            1: begin r = lo; g = v; b = v; end
            default: begin r = v; g = lo; b = v; end
          endcase
        end
        7: begin
          r = $urandom_range(0, 3);
          g = $urandom_range(0, 3);
          b = $urandom_range(0, 3);
        end
        8: begin
          r = $urandom_range(0, 1) * 255;
          g = $urandom_range(0, 1) ? 255 : $urandom_range(0, 255);
          b = $urandom_range(0, 1) * 255;
        end
        9: begin
          hi = $urandom_range(1, 254);
          g = hi + $urandom_range(0, 2) - 1;
          b = hi + $urandom_range(0, 2) - 1;
          r = hi;
        end
        default: ;
      endcase
      add_pixel(r, g, b, draw_gap(), (i % 125) == 124);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pixel_queue.size() != 0 || start || hsv_pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("summary: %0d pixels sent (%0d grey), %0d results checked, %0d mismatches",
             pixels_sent, grey_pixels, results_checked, mismatches);
    if (mismatches == 0 && hsv_pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
